// ===== hdl/rvc_pkg.sv =====
`timescale 1ns / 1ps

package rvc_pkg;

    // Display area and frame geometry
    localparam logic [8:0] AREA_H       = 9'd192;
    localparam logic [8:0] VSYNC_LINE   = 9'd248;   // 192 + 56
    localparam logic [8:0] HSYNC_BACK   = 9'd42;
    localparam logic [8:0] WIDTH_48     = 9'd448;
    localparam logic [8:0] HEIGHT_48    = 9'd312;
    localparam logic [8:0] WIDTH_128    = 9'd456;
    localparam logic [8:0] HEIGHT_128   = 9'd311;
    localparam logic [8:0] HSYNC_48     = WIDTH_48 - HSYNC_BACK;
    localparam logic [8:0] HSYNC_128    = WIDTH_128 - HSYNC_BACK;
    localparam logic [5:0] INT_TICKS    = 6'd32;

    // Video memory bases and colour masks
    localparam logic [15:0] BITMAP_BASE = 16'h4000;
    localparam logic [15:0] ATTR_BASE   = 16'h5800;
    localparam logic [6:0]  PAPER_MASK  = 7'd120;
    localparam logic [6:0]  INK_MASK    = 7'd71;
    localparam logic [7:0]  PORT_FIXED  = 8'hA0;

    // Fetch phases within a cell pair, indexed by hc[3:0]
    localparam logic [3:0] PH_ADDR      = 4'd0;
    localparam logic [3:0] PH_RAS_BMP   = 4'd2;
    localparam logic [3:0] PH_CAS_BMP0  = 4'd3;
    localparam logic [3:0] PH_LATCH_B0  = 4'd4;
    localparam logic [3:0] PH_CAS_ATT0  = 4'd5;
    localparam logic [3:0] PH_LOAD0     = 4'd6;
    localparam logic [3:0] PH_CAS_BMP1  = 4'd7;
    localparam logic [3:0] PH_LATCH_B1  = 4'd8;
    localparam logic [3:0] PH_CAS_ATT1  = 4'd9;
    localparam logic [3:0] PH_LATCH_A1  = 4'd10;
    localparam logic [3:0] PH_LOAD1     = 4'd14;
    localparam logic [3:0] PH_FREE      = 4'd12;

    // Configuration register indexes
    localparam logic REG_MACHINE_MODEL = 1'b0;

    // Widths of the stream payloads
    localparam int IN_W  = 24;
    localparam int OUT_W = 48;

    // Raster position shared with the video logic
    typedef struct packed {
        logic [8:0] hc;
        logic [8:0] vc;
        logic       flash;
    } t_raster_info;

endpackage

// ===== hdl/rvc_raster.sv =====
`timescale 1ns / 1ps

module rvc_raster
    import rvc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic         i_model,
    output t_raster_info o_info,
    output logic         o_psg_clock,
    output logic [1:0]   o_sync,
    output logic         o_interrupt
);

    logic [8:0] r_hc, n_hc;
    logic [8:0] r_vc, n_vc;
    logic [5:0] r_int, n_int;
    logic [1:0] r_psg, n_psg;
    logic [4:0] r_flash, n_flash;
    logic [1:0] n_sync;
    logic [8:0] width, height, hsync_at;

    assign o_info.hc    = r_hc;
    assign o_info.vc    = r_vc;
    assign o_info.flash = r_flash[4];
    assign o_psg_clock  = r_psg[0] & r_psg[1];
    assign o_sync       = n_sync;
    assign o_interrupt  = (n_int != 6'd0);

    // Advance the beam counters, flash phase, PSG divider and interrupt timer, and flag the sync pulses
    always_comb begin
        width    = i_model ? WIDTH_128 : WIDTH_48;
        height   = i_model ? HEIGHT_128 : HEIGHT_48;
        hsync_at = i_model ? HSYNC_128 : HSYNC_48;
        n_psg    = r_hc[0] ? (r_psg ^ 2'b10) : (r_psg ^ 2'b01);
        n_hc     = r_hc + 9'd1;
        n_vc     = r_vc;
        n_int    = r_int;
        n_flash  = r_flash;
        n_sync   = 2'b00;
        if (n_hc == hsync_at) begin
            n_sync[0] = 1'b1;
            n_vc      = r_vc + 9'd1;
            if (n_vc == VSYNC_LINE) begin
                n_sync[1] = 1'b1;
                n_flash   = r_flash + 5'd1;
            end else if (n_vc == height) begin
                n_vc = 9'd0;
            end
        end else if (n_hc == width) begin
            n_hc = 9'd0;
            if (r_vc == VSYNC_LINE) begin
                n_int = INT_TICKS;
            end
        end else if (r_int != 6'd0) begin
            n_int = r_int - {5'd0, r_hc[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc    <= '0;
            r_vc    <= '0;
            r_int   <= '0;
            r_psg   <= 2'b01;
            r_flash <= '0;
        end else if (i_step) begin
            r_hc    <= n_hc;
            r_vc    <= n_vc;
            r_int   <= n_int;
            r_psg   <= n_psg;
            r_flash <= n_flash;
        end
    end

endmodule

// ===== hdl/rvc_video.sv =====
`timescale 1ns / 1ps

module rvc_video
    import rvc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  t_raster_info i_info,
    input  logic         i_a14,
    input  logic         i_a15,
    input  logic         i_io_request,
    input  logic         i_mem_request,
    input  logic         i_read_strobe,
    input  logic         i_write_strobe,
    input  logic         i_ear_level,
    input  logic         i_video_bank,
    input  logic [7:0]   i_data_in,
    input  logic [4:0]   i_key_data,
    output logic         o_cpu_clock,
    output logic [2:0]   o_dram_strobes,
    output logic         o_rom_select,
    output logic [15:0]  o_video_address,
    output logic         o_address_drive,
    output logic [7:0]   o_port_data,
    output logic         o_data_drive,
    output logic [3:0]   o_pixel_rgbi,
    output logic [1:0]   o_audio_out
);

    logic [7:0]  r_bitmap, n_bitmap;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_attr, n_attr;
    logic [6:0]  r_cp0, n_cp0;
    logic [6:0]  r_cp1, n_cp1;
    logic [15:0] r_fa0, n_fa0;
    logic [15:0] r_fa1, n_fa1;
    logic [3:0]  r_draw, n_draw;
    logic [2:0]  r_bord0, n_bord0;
    logic [2:0]  r_bord1, n_bord1;
    logic [1:0]  r_audio, n_audio;

    logic        in_area, hbit, clk, ras, cas, we, do_load, swap;
    logic [3:0]  ph;
    logic [12:0] pos;
    logic [7:0]  load_attr;
    logic [6:0]  colour;
    logic [15:0] vaddr;
    logic        adrive;
    logic [7:0]  pdata;
    logic        ddrive;
    logic [3:0]  pixel;

    assign o_cpu_clock     = clk;
    assign o_dram_strobes  = {we, cas, ras};
    assign o_rom_select    = ~i_a14 & ~i_a15 & i_read_strobe;
    assign o_video_address = vaddr;
    assign o_address_drive = adrive;
    assign o_port_data     = pdata;
    assign o_data_drive    = ddrive;
    assign o_pixel_rgbi    = pixel;
    assign o_audio_out     = n_audio;

    // Fetch, contention, port access and pixel shift for one tick
    always_comb begin
        n_bitmap  = r_bitmap;
        n_shift   = r_shift;
        n_attr    = r_attr;
        n_cp0     = r_cp0;
        n_cp1     = r_cp1;
        n_fa0     = r_fa0;
        n_fa1     = r_fa1;
        n_draw    = r_draw;
        n_bord0   = r_bord0;
        n_bord1   = r_bord1;
        n_audio   = r_audio;
        hbit      = i_info.hc[0];
        clk       = hbit;
        ras       = 1'b0;
        cas       = 1'b0;
        vaddr     = 16'd0;
        adrive    = 1'b0;
        pdata     = 8'hFF;
        ddrive    = 1'b0;
        do_load   = 1'b0;
        load_attr = r_attr;
        in_area   = ~i_info.hc[8] && (i_info.vc < AREA_H);
        ph        = i_info.hc[3:0];
        pos       = {i_info.vc[7:0], i_info.hc[7:3]};

        if (in_area) begin
            unique case (ph)
                PH_ADDR: begin
                    n_fa0 = {i_video_bank, 15'd0} | BITMAP_BASE
                          | {3'd0, pos[12:11], pos[7:5], pos[10:8], pos[4:0]};
                    n_fa1 = {i_video_bank, 15'd0} | ATTR_BASE
                          | {6'd0, pos[12:11], 8'd0};
                end
                PH_RAS_BMP: begin
                    vaddr  = r_fa0;
                    adrive = 1'b1;
                    ras    = 1'b1;
                end
                PH_CAS_BMP0, PH_CAS_BMP1: begin
                    vaddr  = r_fa0;
                    adrive = 1'b1;
                    cas    = 1'b1;
                end
                PH_LATCH_B0, PH_LATCH_B1: begin
                    n_bitmap = i_data_in;
                end
                PH_CAS_ATT0, PH_CAS_ATT1: begin
                    vaddr  = r_fa1;
                    adrive = 1'b1;
                    cas    = 1'b1;
                end
                PH_LOAD0: begin
                    n_attr    = i_data_in;
                    load_attr = i_data_in;
                    do_load   = 1'b1;
                    n_fa0     = r_fa0 + 16'd1;
                    vaddr     = n_fa0;
                    adrive    = 1'b1;
                    ras       = 1'b1;
                end
                PH_LATCH_A1: begin
                    n_attr = i_data_in;
                end
                PH_LOAD1: begin
                    do_load = 1'b1;
                end
                default: begin
                end
            endcase
            // Hold the CPU clock low while it contends for video memory
            if (ph < PH_FREE) begin
                if (i_a14 | i_io_request) begin
                    clk = 1'b0;
                    if (i_io_request && !(i_read_strobe | i_write_strobe)) begin
                        clk = hbit;
                    end
                end
            end else if (i_a14) begin
                cas = 1'b1;
            end
        end

        // Load the next cell into the shifter, swapping ink and paper on flash
        swap = load_attr[7] & i_info.flash;
        if (do_load) begin
            n_shift = r_bitmap;
            n_draw  = 4'd8;
            if (swap) begin
                n_cp1 = load_attr[6:0] & PAPER_MASK;
                n_cp0 = load_attr[6:0] & INK_MASK;
            end else begin
                n_cp0 = load_attr[6:0] & PAPER_MASK;
                n_cp1 = load_attr[6:0] & INK_MASK;
            end
        end

        // CPU access to the upper DRAM
        ras = ras | (clk & i_mem_request & i_a14);
        cas = cas | (clk & i_mem_request & i_a14);
        we  = clk & i_mem_request & i_write_strobe & i_a14;

        // Port read wins over port write
        if (i_io_request) begin
            if (i_read_strobe) begin
                pdata  = PORT_FIXED | {1'b0, i_ear_level, 1'b0, i_key_data};
                ddrive = 1'b1;
            end else if (i_write_strobe) begin
                n_bord0 = i_data_in[2:0];
                n_audio = {i_data_in[4], i_data_in[3]};
            end
        end

        // Shift out a pixel or show the border
        colour = n_shift[7] ? n_cp1 : n_cp0;
        if (n_draw == 4'd0) begin
            if (i_info.hc[2:0] == 3'd6) begin
                n_bord1 = n_bord0;
            end
            pixel = {1'b0, n_bord1};
        end else begin
            pixel   = colour[6:3] | {1'b0, colour[2:0]};
            n_draw  = n_draw - 4'd1;
            n_shift = {n_shift[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap <= '0;
            r_shift  <= '0;
            r_attr   <= '0;
            r_cp0    <= '0;
            r_cp1    <= '0;
            r_fa0    <= '0;
            r_fa1    <= '0;
            r_draw   <= '0;
            r_bord0  <= '0;
            r_bord1  <= '0;
            r_audio  <= '0;
        end else if (i_step) begin
            r_bitmap <= n_bitmap;
            r_shift  <= n_shift;
            r_attr   <= n_attr;
            r_cp0    <= n_cp0;
            r_cp1    <= n_cp1;
            r_fa0    <= n_fa0;
            r_fa1    <= n_fa1;
            r_draw   <= n_draw;
            r_bord0  <= n_bord0;
            r_bord1  <= n_bord1;
            r_audio  <= n_audio;
        end
    end

endmodule

// ===== hdl/rvc_outq.sv =====
`timescale 1ns / 1ps

module rvc_outq
    import rvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [OUT_W-1:0] i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [OUT_W-1:0] o_data
);

    logic [OUT_W-1:0] r_q [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;
    logic             pop_ok;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];
    assign pop_ok  = i_pop & o_valid;

    // Store results; the second slot lets a request in while one waits
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop_ok) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop_ok};
        end
    end

endmodule

// ===== hdl/raster_video_contention_ula.sv =====
`timescale 1ns / 1ps
// Each accepted request's result is registered into a two-entry queue, behind any
// older result. Throughput: one request per cycle while the queue has space; the
// queue keeps s_axis_tready high while one result waits on the master side.
// Reset: synchronous, active low; counters, latches and the queue clear, the
// machine model returns to 448x312 ticks.
module raster_video_contention_ula
    import rvc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [0] a14 [1] a15 [2] io_request [3] mem_request [4] read_strobe
    // [5] write_strobe [6] ear_level [7] video_bank [15:8] data_in [20:16] key_data
    input  logic [IN_W-1:0]   s_axis_tdata,
    // master stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] cpu_clock [1] psg_clock [4:2] dram_strobes [5] rom_select
    // [21:6] video_address [22] address_drive [30:23] port_data [31] data_drive
    // [35:32] pixel_rgbi [37:36] sync_pulse [38] interrupt_line [40:39] audio_out
    output logic [OUT_W-1:0]  m_axis_tdata,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic         r_model;
    logic         step;
    t_raster_info info;
    logic         psg_clock, interrupt;
    logic [1:0]   sync;
    logic         cpu_clock, rom_select, address_drive, data_drive;
    logic [2:0]   dram_strobes;
    logic [15:0]  video_address;
    logic [7:0]   port_data;
    logic [3:0]   pixel;
    logic [1:0]   audio;
    logic [OUT_W-1:0] result;
    logic         space;

    // Hold off requests while in reset
    assign pready        = 1'b1;
    assign s_axis_tready = space & i_rst_n;
    assign step          = s_axis_tvalid & s_axis_tready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_MACHINE_MODEL)) begin
            r_model <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_MACHINE_MODEL) ? {31'd0, r_model} : 32'd0;

    rvc_raster u_raster (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_model     (r_model),
        .o_info      (info),
        .o_psg_clock (psg_clock),
        .o_sync      (sync),
        .o_interrupt (interrupt)
    );

    rvc_video u_video (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_info          (info),
        .i_a14           (s_axis_tdata[0]),
        .i_a15           (s_axis_tdata[1]),
        .i_io_request    (s_axis_tdata[2]),
        .i_mem_request   (s_axis_tdata[3]),
        .i_read_strobe   (s_axis_tdata[4]),
        .i_write_strobe  (s_axis_tdata[5]),
        .i_ear_level     (s_axis_tdata[6]),
        .i_video_bank    (s_axis_tdata[7]),
        .i_data_in       (s_axis_tdata[15:8]),
        .i_key_data      (s_axis_tdata[20:16]),
        .o_cpu_clock     (cpu_clock),
        .o_dram_strobes  (dram_strobes),
        .o_rom_select    (rom_select),
        .o_video_address (video_address),
        .o_address_drive (address_drive),
        .o_port_data     (port_data),
        .o_data_drive    (data_drive),
        .o_pixel_rgbi    (pixel),
        .o_audio_out     (audio)
    );

    // Pack the result request
    assign result = {7'd0, audio, interrupt, sync, pixel, data_drive, port_data,
                     address_drive, video_address, rom_select, dram_strobes,
                     psg_clock, cpu_clock};

    rvc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (result),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule
